### rtl/dll_pkg.sv
package dll_pkg;

   // Defaults for the top level parameters
   localparam int CAPACITY_DEFAULT    = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Fixed port field widths
   localparam int ACTION_WIDTH = 2;
   localparam int DATA_WIDTH   = 32;
   localparam int STATUS_WIDTH = 3;
   localparam int COUNT_WIDTH  = 5;

   // Request actions
   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_PUSH_FRONT = 2'd0,
      ACT_PUSH_BACK  = 2'd1,
      ACT_DELETE     = 2'd2,
      ACT_LIST       = 2'd3
   } action_type;

   // Result status codes
   typedef enum logic [STATUS_WIDTH-1:0] {
      STAT_DONE      = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_NOT_FOUND = 3'd2,
      STAT_ENTRY     = 3'd3,
      STAT_EMPTY     = 3'd4
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_PUSH_LINK,
      S_WALK,
      S_DEL_PREV,
      S_DEL_NEXT,
      S_EMIT
   } state_type;

   // Per-field write enables of the node memory
   typedef struct packed {
      logic value_en;
      logic next_en;
      logic prev_en;
   } field_we_type;

endpackage

### rtl/dll_node_mem.sv
module dll_node_mem #(
   parameter int DEPTH       = dll_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = dll_pkg::VALUE_WIDTH_DEFAULT,
   parameter int INDEX_WIDTH = $clog2(DEPTH + 1)
) (
   input  logic                       clock,
   // write port, one entry, field enables
   input  dll_pkg::field_we_type      wr_we,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [VALUE_WIDTH-1:0]     wr_value,
   input  logic [INDEX_WIDTH-1:0]     wr_next,
   input  logic [INDEX_WIDTH-1:0]     wr_prev,
   // read port, registered data
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [VALUE_WIDTH-1:0]     rd_value,
   output logic [INDEX_WIDTH-1:0]     rd_next,
   output logic [INDEX_WIDTH-1:0]     rd_prev
);

   // node pool: value, forward and backward link per entry
   logic [VALUE_WIDTH-1:0] value_mem [DEPTH];
   logic [INDEX_WIDTH-1:0] next_mem  [DEPTH];
   logic [INDEX_WIDTH-1:0] prev_mem  [DEPTH];

   logic [VALUE_WIDTH-1:0] rd_value_ff;
   logic [INDEX_WIDTH-1:0] rd_next_ff;
   logic [INDEX_WIDTH-1:0] rd_prev_ff;

   // write with field enables
   always_ff @(posedge clock) begin
      if (wr_we.value_en) begin
         value_mem[wr_addr] <= wr_value;
      end
      if (wr_we.next_en) begin
         next_mem[wr_addr] <= wr_next;
      end
      if (wr_we.prev_en) begin
         prev_mem[wr_addr] <= wr_prev;
      end
   end

   // read, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_value_ff <= value_mem[rd_addr];
         rd_next_ff  <= next_mem[rd_addr];
         rd_prev_ff  <= prev_mem[rd_addr];
      end
   end

   assign rd_value = rd_value_ff;
   assign rd_next  = rd_next_ff;
   assign rd_prev  = rd_prev_ff;

endmodule

### rtl/dll_free_map.sv
module dll_free_map #(
   parameter int CAPACITY = dll_pkg::CAPACITY_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          alloc_en,
   input  logic                          release_en,
   input  logic [$clog2(CAPACITY)-1:0]   release_idx,
   output logic [$clog2(CAPACITY)-1:0]   alloc_idx,
   output logic                          full
);

   localparam int AW = $clog2(CAPACITY);

   logic [CAPACITY-1:0] free_ff;
   logic [CAPACITY-1:0] free_in;
   logic [CAPACITY-1:0] lowest;
   logic [AW-1:0]       idx;

   // isolate lowest free slot, then encode the one-hot
   always_comb begin
      lowest = free_ff & (~free_ff + CAPACITY'(1));
      idx    = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (lowest[i]) begin
            idx = idx | AW'(i);
         end
      end
   end

   assign alloc_idx = idx;
   assign full      = (free_ff == '0);

   // take and give back slots
   always_comb begin
      free_in = free_ff;
      if (alloc_en) begin
         free_in = free_in & ~lowest;
      end
      if (release_en) begin
         free_in[release_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '1;
      end else begin
         free_ff <= free_in;
      end
   end

endmodule

### rtl/dll_rsp_reg.sv
module dll_rsp_reg (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  dll_pkg::status_type                   load_status,
   input  logic signed [dll_pkg::DATA_WIDTH-1:0] load_value,
   input  logic                                  load_last,
   input  logic [dll_pkg::COUNT_WIDTH-1:0]       load_count,
   output logic                                  slot_free,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [dll_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic signed [dll_pkg::DATA_WIDTH-1:0] rsp_item_value,
   output logic                                  rsp_is_last,
   output logic [dll_pkg::COUNT_WIDTH-1:0]       rsp_entry_count
);

   logic                                  valid_ff;
   logic                                  valid_in;
   dll_pkg::status_type                   status_ff;
   logic signed [dll_pkg::DATA_WIDTH-1:0] value_ff;
   logic                                  last_ff;
   logic [dll_pkg::COUNT_WIDTH-1:0]       count_ff;

   // slot can take a new item when empty or being drained this cycle
   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= load_status;
         value_ff  <= load_value;
         last_ff   <= load_last;
         count_ff  <= load_count;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_item_value  = value_ff;
   assign rsp_is_last     = last_ff;
   assign rsp_entry_count = count_ff;

endmodule

### rtl/doubly_linked_list_manager_core.sv
// Channel   | Direction | Handshake          | Payload
// req       | in        | req_valid/req_stall | req_action, req_operand_value
// rsp       | out       | rsp_valid/rsp_stall | rsp_status, rsp_item_value,
//           |           |                     | rsp_is_last, rsp_entry_count
//
// One item at a time. Push: write the new node, then rewrite a neighbor link
// if the list was not empty. Delete: visit one node per read, paced by the single
// read port of the node memory, and on a hit relink the previous and next nodes.
// List: one entry per node read; empty goes straight to the result, as for a delete.
// Synchronous reset clears free map, head, tail, count and control; the node
// memory is not cleared. A stalled rsp pauses the list walk in place.
module doubly_linked_list_manager_core #(
   parameter int CAPACITY    = dll_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = dll_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [dll_pkg::ACTION_WIDTH-1:0]      req_action,
   input  logic signed [dll_pkg::DATA_WIDTH-1:0] req_operand_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [dll_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic signed [dll_pkg::DATA_WIDTH-1:0] rsp_item_value,
   output logic                                  rsp_is_last,
   output logic [dll_pkg::COUNT_WIDTH-1:0]       rsp_entry_count
);

   localparam int IW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam logic [IW-1:0] NULL_IDX = IW'(CAPACITY);

   dll_pkg::state_type  state_ff, state_in;
   dll_pkg::action_type action_ff, action_in;
   dll_pkg::status_type pend_ff, pend_in;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [IW-1:0] length_ff, length_in;
   logic [IW-1:0] node_ff, node_in;
   logic [IW-1:0] nbr_ff, nbr_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] steps_ff, steps_in;
   logic [IW-1:0] prev_ff, prev_in;
   logic [IW-1:0] next_ff, next_in;

   dll_pkg::action_type    req_act;
   logic [VALUE_WIDTH-1:0] req_key;
   logic                   req_accept;
   logic                   req_push;
   logic                   req_front;
   logic [IW-1:0]          req_nbr;

   // memory ports
   dll_pkg::field_we_type  wr_we;
   logic [AW-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0] wr_value;
   logic [IW-1:0]          wr_next;
   logic [IW-1:0]          wr_prev;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [VALUE_WIDTH-1:0] rd_value;
   logic [IW-1:0]          rd_next;
   logic [IW-1:0]          rd_prev;

   // free map ports
   logic                   alloc_en;
   logic                   release_en;
   logic [AW-1:0]          alloc_idx;
   logic                   pool_full;

   // result register ports
   logic                                  out_load;
   dll_pkg::status_type                   out_status;
   logic signed [dll_pkg::DATA_WIDTH-1:0] out_value;
   logic                                  out_last;
   logic                                  slot_free;

   logic walk_match;
   logic walk_end;

   // request decode
   assign req_stall  = (state_ff != dll_pkg::S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_act    = dll_pkg::action_type'(req_action);
   assign req_key    = VALUE_WIDTH'(req_operand_value);
   assign req_push   = (req_act == dll_pkg::ACT_PUSH_FRONT) ||
                       (req_act == dll_pkg::ACT_PUSH_BACK);
   assign req_front  = (req_act == dll_pkg::ACT_PUSH_FRONT);
   assign req_nbr    = req_front ? head_ff : tail_ff;

   // walk status on the node just read
   assign walk_match = (rd_value == key_ff);
   assign walk_end   = (rd_next == NULL_IDX) || (steps_ff == IW'(CAPACITY));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dll_pkg::S_IDLE: begin
            if (req_accept) begin
               if (req_push) begin
                  if (pool_full || req_nbr == NULL_IDX) begin
                     state_in = dll_pkg::S_EMIT;
                  end else begin
                     state_in = dll_pkg::S_PUSH_LINK;
                  end
               end else if (head_ff == NULL_IDX) begin
                  state_in = dll_pkg::S_EMIT;
               end else begin
                  state_in = dll_pkg::S_WALK;
               end
            end
         end
         dll_pkg::S_PUSH_LINK: begin
            state_in = dll_pkg::S_EMIT;
         end
         dll_pkg::S_WALK: begin
            if (action_ff == dll_pkg::ACT_DELETE) begin
               if (walk_match) begin
                  state_in = dll_pkg::S_DEL_PREV;
               end else if (walk_end) begin
                  state_in = dll_pkg::S_EMIT;
               end
            end else if (slot_free && walk_end) begin
               state_in = dll_pkg::S_IDLE;
            end
         end
         dll_pkg::S_DEL_PREV: begin
            state_in = dll_pkg::S_DEL_NEXT;
         end
         dll_pkg::S_DEL_NEXT: begin
            state_in = dll_pkg::S_EMIT;
         end
         dll_pkg::S_EMIT: begin
            if (slot_free) begin
               state_in = dll_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dll_pkg::S_IDLE;
         end
      endcase
   end

   // datapath control per state
   always_comb begin
      action_in  = action_ff;
      pend_in    = pend_ff;
      key_in     = key_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      length_in  = length_ff;
      node_in    = node_ff;
      nbr_in     = nbr_ff;
      cur_in     = cur_ff;
      steps_in   = steps_ff;
      prev_in    = prev_ff;
      next_in    = next_ff;
      wr_we      = '0;
      wr_addr    = alloc_idx;
      wr_value   = req_key;
      wr_next    = NULL_IDX;
      wr_prev    = NULL_IDX;
      rd_en      = 1'b0;
      rd_addr    = head_ff[AW-1:0];
      alloc_en   = 1'b0;
      release_en = 1'b0;
      out_load   = 1'b0;
      out_status = pend_ff;
      out_value  = '0;
      out_last   = 1'b1;

      unique case (state_ff)
         dll_pkg::S_IDLE: begin
            if (req_accept) begin
               action_in = req_act;
               key_in    = req_key;
               if (req_push) begin
                  if (pool_full) begin
                     pend_in = dll_pkg::STAT_FULL;
                  end else begin
                     // new node written in full at the lowest free slot
                     alloc_en = 1'b1;
                     wr_we    = '{value_en: 1'b1, next_en: 1'b1, prev_en: 1'b1};
                     wr_next  = req_front ? head_ff : NULL_IDX;
                     wr_prev  = req_front ? NULL_IDX : tail_ff;
                     node_in  = IW'(alloc_idx);
                     nbr_in   = req_nbr;
                     if (req_front) begin
                        head_in = IW'(alloc_idx);
                        if (head_ff == NULL_IDX) begin
                           tail_in = IW'(alloc_idx);
                        end
                     end else begin
                        tail_in = IW'(alloc_idx);
                        if (tail_ff == NULL_IDX) begin
                           head_in = IW'(alloc_idx);
                        end
                     end
                     length_in = length_ff + IW'(1);
                     pend_in   = dll_pkg::STAT_DONE;
                  end
               end else if (head_ff == NULL_IDX) begin
                  pend_in = (req_act == dll_pkg::ACT_DELETE) ?
                            dll_pkg::STAT_NOT_FOUND : dll_pkg::STAT_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = head_ff[AW-1:0];
                  cur_in   = head_ff;
                  steps_in = IW'(1);
               end
            end
         end
         dll_pkg::S_PUSH_LINK: begin
            // old head gets a back link, or old tail a forward link
            wr_addr = nbr_ff[AW-1:0];
            wr_next = node_ff;
            wr_prev = node_ff;
            if (action_ff == dll_pkg::ACT_PUSH_FRONT) begin
               wr_we.prev_en = 1'b1;
            end else begin
               wr_we.next_en = 1'b1;
            end
         end
         dll_pkg::S_WALK: begin
            if (action_ff == dll_pkg::ACT_DELETE) begin
               if (walk_match) begin
                  prev_in = rd_prev;
                  next_in = rd_next;
               end else if (walk_end) begin
                  pend_in = dll_pkg::STAT_NOT_FOUND;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = rd_next[AW-1:0];
                  cur_in   = rd_next;
                  steps_in = steps_ff + IW'(1);
               end
            end else if (slot_free) begin
               // list: one entry per cycle while the result slot drains
               out_load   = 1'b1;
               out_status = dll_pkg::STAT_ENTRY;
               out_value  = dll_pkg::DATA_WIDTH'($signed(rd_value));
               out_last   = walk_end;
               if (!walk_end) begin
                  rd_en    = 1'b1;
                  rd_addr  = rd_next[AW-1:0];
                  cur_in   = rd_next;
                  steps_in = steps_ff + IW'(1);
               end
            end
         end
         dll_pkg::S_DEL_PREV: begin
            release_en = 1'b1;
            if (length_ff != '0) begin
               length_in = length_ff - IW'(1);
            end
            wr_addr = prev_ff[AW-1:0];
            wr_next = next_ff;
            if (prev_ff != NULL_IDX) begin
               wr_we.next_en = 1'b1;
            end else begin
               head_in = next_ff;
            end
         end
         dll_pkg::S_DEL_NEXT: begin
            wr_addr = next_ff[AW-1:0];
            wr_prev = prev_ff;
            if (next_ff != NULL_IDX) begin
               wr_we.prev_en = 1'b1;
            end else begin
               tail_in = prev_ff;
            end
            pend_in = dll_pkg::STAT_DONE;
         end
         dll_pkg::S_EMIT: begin
            out_load = slot_free;
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dll_pkg::S_IDLE;
         head_ff   <= NULL_IDX;
         tail_ff   <= NULL_IDX;
         length_ff <= '0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         length_ff <= length_in;
      end
   end

   // per-request working registers
   always_ff @(posedge clock) begin
      action_ff <= action_in;
      pend_ff   <= pend_in;
      key_ff    <= key_in;
      node_ff   <= node_in;
      nbr_ff    <= nbr_in;
      cur_ff    <= cur_in;
      steps_ff  <= steps_in;
      prev_ff   <= prev_in;
      next_ff   <= next_in;
   end

   dll_node_mem #(
      .DEPTH       (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH),
      .INDEX_WIDTH (IW)
   ) u_node_mem (
      .clock    (clock),
      .wr_we    (wr_we),
      .wr_addr  (wr_addr),
      .wr_value (wr_value),
      .wr_next  (wr_next),
      .wr_prev  (wr_prev),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_value (rd_value),
      .rd_next  (rd_next),
      .rd_prev  (rd_prev)
   );

   dll_free_map #(
      .CAPACITY (CAPACITY)
   ) u_free_map (
      .clock       (clock),
      .reset       (reset),
      .alloc_en    (alloc_en),
      .release_en  (release_en),
      .release_idx (cur_ff[AW-1:0]),
      .alloc_idx   (alloc_idx),
      .full        (pool_full)
   );

   dll_rsp_reg u_rsp_reg (
      .clock           (clock),
      .reset           (reset),
      .load            (out_load),
      .load_status     (out_status),
      .load_value      (out_value),
      .load_last       (out_last),
      .load_count      (dll_pkg::COUNT_WIDTH'(length_ff)),
      .slot_free       (slot_free),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_item_value  (rsp_item_value),
      .rsp_is_last     (rsp_is_last),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

### rtl/dll_checker.sv
module dll_checker #(
   parameter int CAPACITY = dll_pkg::CAPACITY_DEFAULT
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [dll_pkg::STATUS_WIDTH-1:0]      rsp_status,
   input logic signed [dll_pkg::DATA_WIDTH-1:0] rsp_item_value,
   input logic                                  rsp_is_last,
   input logic [dll_pkg::COUNT_WIDTH-1:0]       rsp_entry_count
);

   // no result shows right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_item_value) && $stable(rsp_is_last) && $stable(rsp_entry_count))
      else $error("stalled result changed");

   // only list entries carry a value, every other status closes its request
   a_single_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dll_pkg::STAT_ENTRY |->
         rsp_item_value == '0 && rsp_is_last)
      else $error("non-entry result with value or not last");

   // a refused push only happens on a full pool
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == dll_pkg::STAT_FULL |->
         rsp_entry_count == dll_pkg::COUNT_WIDTH'(CAPACITY))
      else $error("full refusal with pool not full");

   // an empty listing reports no entries
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == dll_pkg::STAT_EMPTY |-> rsp_entry_count == '0)
      else $error("empty listing with entries");

endmodule

bind doubly_linked_list_manager_core dll_checker #(
   .CAPACITY (CAPACITY)
) u_dll_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_item_value    (rsp_item_value),
   .rsp_is_last       (rsp_is_last),
   .rsp_entry_count   (rsp_entry_count)
);
